// ===== design/dsps_pkg.sv =====
// Shared types, constants and control structures for the daily slot pump scheduler.
`default_nettype none
package dsps_pkg;

	localparam int SLOTS_DEF      = 10;
	localparam int DAY_MINUTES    = 1440;
	localparam int MINUTE_SECONDS = 60;
	localparam int MAX_HOUR       = 23;
	localparam int MAX_MINUTE     = 59;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_WRITE   = 2'd1,
		KIND_MANUAL  = 2'd2,
		KIND_RESCHED = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  now_hour;
		logic [5:0]  now_minute;
		logic [5:0]  now_second;
		logic [3:0]  slot_number;
		logic [4:0]  start_hour;
		logic [5:0]  start_minute;
		logic [15:0] run_seconds;
		logic        slot_enabled;
		logic [15:0] manual_seconds;
	} item_t;

	typedef struct packed {
		logic        pump_on;
		logic [15:0] remaining_run;
		logic [16:0] seconds_to_start;
		logic        next_found;
		logic [3:0]  next_slot;
		logic [4:0]  next_hour;
		logic [5:0]  next_minute;
		logic [15:0] next_duration;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_clr;
		logic scan_step;
		logic apply;
		logic resp;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== design/dsps_datapath.sv =====
// Datapath of the scheduler: slot table, countdown, slot scan and result register.
`default_nettype none
module dsps_datapath #(
	parameter int SLOTS = dsps_pkg::SLOTS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  dsps_pkg::item_t      item,
	input  dsps_pkg::ctl_cmd_t   cmd,
	output dsps_pkg::dp_status_t sts,
	output dsps_pkg::result_t    result
);
	import dsps_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	item_t          item_q;
	logic [16:0]    cd_q;
	logic [15:0]    pend_q;
	logic           pump_q;
	logic [IW-1:0]  nidx_q;
	logic           nvld_q;
	logic [4:0]     nhour_q;
	logic [5:0]     nmin_q;

	logic [SLOTS-1:0] svld_q;
	logic [4:0]       shour_q [SLOTS];
	logic [5:0]       smin_q  [SLOTS];
	logic [15:0]      sdur_q  [SLOTS];

	logic [IW-1:0]  idx_q;
	logic [10:0]    best_q;
	logic [10:0]    now_q;
	logic [5:0]     sec_q;
	logic [IW-1:0]  bidx_q;
	logic [4:0]     bhour_q;
	logic [5:0]     bmin_q;
	logic [15:0]    bdur_q;
	result_t        res_q;

	logic [4:0]     hsat;
	logic [5:0]     msat;
	logic [5:0]     ssat;
	logic [10:0]    now_c;
	logic           wr_ok;
	logic           wr_clr;
	logic [IW-1:0]  wr_addr;
	logic [16:0]    cd_dec;
	logic [10:0]    v_c;
	logic [10:0]    d_c;
	logic           take;
	logic           found;
	logic [16:0]    cd_new;
	result_t        res_c;

	always_comb begin
		hsat  = (item_q.now_hour > 5'(MAX_HOUR)) ? 5'(MAX_HOUR) : item_q.now_hour;
		msat  = (item_q.now_minute > 6'(MAX_MINUTE)) ? 6'(MAX_MINUTE) : item_q.now_minute;
		ssat  = (item_q.now_second > 6'(MAX_MINUTE)) ? 6'(MAX_MINUTE) : item_q.now_second;
		now_c = 11'(hsat) * 11'(MINUTE_SECONDS) + 11'(msat);

		wr_ok   = (item_q.kind == KIND_WRITE) && (item_q.slot_number != 4'd0)
			&& (item_q.slot_number <= 4'(SLOTS));
		wr_clr  = (item_q.start_hour > 5'(MAX_HOUR)) || (item_q.start_minute > 6'(MAX_MINUTE))
			|| (item_q.run_seconds == 16'd0);
		wr_addr = IW'(item_q.slot_number - 4'd1);

		cd_dec = cd_q - 17'd1;
		sts.need_scan = (item_q.kind == KIND_RESCHED)
			|| ((item_q.kind == KIND_TICK) && (cd_q == 17'd1) && pump_q);
		sts.scan_last = (idx_q == IW'(SLOTS - 1));

		v_c  = 11'(shour_q[idx_q]) * 11'(MINUTE_SECONDS) + 11'(smin_q[idx_q]);
		d_c  = v_c - now_q + ((v_c > now_q) ? 11'd0 : 11'(DAY_MINUTES));
		take = svld_q[idx_q] && (d_c < best_q);

		found  = (best_q < 11'(DAY_MINUTES));
		cd_new = 17'(best_q) * 17'(MINUTE_SECONDS) - 17'(sec_q);

		res_c.pump_on          = pump_q;
		res_c.remaining_run    = !pump_q ? 16'd0 : ((cd_q > 17'hFFFF) ? 16'hFFFF : cd_q[15:0]);
		res_c.seconds_to_start = pump_q ? 17'd0 : cd_q;
		res_c.next_found       = nvld_q;
		res_c.next_slot        = nvld_q ? 4'(nidx_q) : 4'd0;
		res_c.next_hour        = nvld_q ? nhour_q : 5'd0;
		res_c.next_minute      = nvld_q ? nmin_q : 6'd0;
		res_c.next_duration    = nvld_q ? pend_q : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q    <= '0;
			pend_q  <= '0;
			pump_q  <= 1'b0;
			nidx_q  <= '0;
			nvld_q  <= 1'b0;
			nhour_q <= '0;
			nmin_q  <= '0;
			svld_q  <= '0;
			idx_q   <= '0;
			best_q  <= '0;
		end else begin
			if (cmd.exec) begin
				case (item_q.kind)
					KIND_TICK: begin
						if (cd_q != 17'd0) begin
							cd_q <= ((cd_dec == 17'd0) && !pump_q) ? 17'(pend_q) : cd_dec;
							if (cd_dec == 17'd0) begin
								pump_q <= !pump_q;
							end
						end
					end
					KIND_WRITE: begin
						if (wr_ok) begin
							svld_q[wr_addr] <= !wr_clr;
							if (wr_addr == nidx_q) begin
								nhour_q <= wr_clr ? 5'd0 : item_q.start_hour;
								nmin_q  <= wr_clr ? 6'd0 : item_q.start_minute;
							end
						end
					end
					KIND_MANUAL: begin
						if (item_q.manual_seconds != 16'd0) begin
							cd_q   <= 17'(item_q.manual_seconds);
							pump_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan_clr) begin
				idx_q  <= '0;
				best_q <= 11'(DAY_MINUTES);
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + IW'(1);
				if (take) begin
					best_q <= d_c;
				end
			end
			if (cmd.apply) begin
				if (found) begin
					cd_q    <= cd_new;
					pend_q  <= bdur_q;
					nidx_q  <= bidx_q;
					nvld_q  <= 1'b1;
					nhour_q <= bhour_q;
					nmin_q  <= bmin_q;
				end else begin
					nvld_q <= 1'b0;
					if (!pump_q) begin
						cd_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.exec && wr_ok && !wr_clr) begin
			shour_q[wr_addr] <= item_q.start_hour;
			smin_q[wr_addr]  <= item_q.start_minute;
			sdur_q[wr_addr]  <= item_q.run_seconds;
		end
		if (cmd.scan_clr) begin
			now_q  <= now_c;
			sec_q  <= ssat;
			bidx_q <= '0;
		end
		if (cmd.scan_step && take) begin
			bidx_q  <= idx_q;
			bhour_q <= shour_q[idx_q];
			bmin_q  <= smin_q[idx_q];
			bdur_q  <= sdur_q[idx_q];
		end
		if (cmd.resp) begin
			res_q <= res_c;
		end
	end

	assign result = res_q;

endmodule
`default_nettype wire

// ===== design/dsps_control.sv =====
// Controller state machine that sequences each word through execute, scan and response.
`default_nettype none
module dsps_control (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  dsps_pkg::dp_status_t sts,
	output dsps_pkg::ctl_cmd_t   cmd,
	output logic                 busy,
	output logic                 done
);
	import dsps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_APPLY,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_RESP);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= sts.need_scan ? ST_SCAN : ST_RESP;
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load      = (state_q == ST_IDLE) && start;
		cmd.exec      = (state_q == ST_EXEC);
		cmd.scan_clr  = (state_q == ST_EXEC) && sts.need_scan;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.apply     = (state_q == ST_APPLY);
		cmd.resp      = (state_q == ST_RESP);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

// ===== design/daily_slot_pump_scheduler.sv =====
// Top level of the daily slot pump scheduler: controller and datapath.
//
// An input word is taken at a rising edge where start is high and busy is low.
// The word is a tick, a slot write, a manual run or a reschedule, as its kind says.
// Exactly one result word follows each input word: done is high for one cycle
// and result carries the pump level, the countdowns and the next scheduled slot.
// The receiver cannot hold a result off; it must take it in the cycle done is high.
// A word that needs no slot scan goes from the execute state to the response state,
// where its result is registered; busy stays high through that state, so a new word
// is taken only once the last one is through. A reschedule, or a tick that ends a
// run, scans the slot table one slot per cycle, then applies the best slot before
// the response. The single shared scan comparator makes the scan go slot by slot.
// Reset clears the slot table, the countdown, the pump and the next-slot record,
// and leaves the block idle with done low.
`default_nettype none
module daily_slot_pump_scheduler #(
	parameter int SLOTS = dsps_pkg::SLOTS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  dsps_pkg::item_t    item,
	output logic               done,
	output dsps_pkg::result_t  result
);
	import dsps_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t sts;

	dsps_control u_control (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dsps_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
`default_nettype wire

// ===== design/dsps_check.sv =====
// Port checker for the scheduler and the bind that attaches it to the top level.
`default_nettype none
module dsps_check (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire               done,
	input dsps_pkg::result_t result
);
	import dsps_pkg::*;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a preceding busy period");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_countdown_side: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.pump_on ? (result.seconds_to_start == 17'd0)
			: (result.remaining_run == 16'd0)))
		else $error("countdown shown on the wrong side of the pump state");

	a_next_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.next_found) |-> ((result.next_slot == 4'd0)
			&& (result.next_duration == 16'd0)))
		else $error("next slot fields not cleared when no slot is known");

endmodule

bind daily_slot_pump_scheduler dsps_check u_dsps_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the daily slot pump scheduler, with its own predictor.
module tb_top;
	import dsps_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam int RANDOM_WORDS = 600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;

	item_t pending_words[$];
	result_t expected_status[$];
	bit word_taken;
	int unsigned sent_count;
	int unsigned total_words;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned day_sec;

	logic [4:0] slot_hour[NSLOT];
	logic [5:0] slot_minute[NSLOT];
	logic [15:0] slot_run[NSLOT];
	int unsigned count_left;
	logic [15:0] queued_run;
	logic pump_level;
	int unsigned next_idx;
	logic next_known;

	daily_slot_pump_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void slot_scan(logic [4:0] h, logic [5:0] m, logic [5:0] s);
		int unsigned now_min, sec, best, idx, v, d;
		now_min = ((h > MAX_HOUR) ? MAX_HOUR : h) * MINUTE_SECONDS
			+ ((m > MAX_MINUTE) ? MAX_MINUTE : m);
		sec = (s > MAX_MINUTE) ? MAX_MINUTE : s;
		best = DAY_MINUTES;
		idx = 0;
		for (int i = 0; i < NSLOT; i++) begin
			if (slot_run[i] != 0) begin
				v = slot_hour[i] * MINUTE_SECONDS + slot_minute[i];
				d = (v > now_min) ? v - now_min : v + DAY_MINUTES - now_min;
				if (d < best) begin
					best = d;
					idx = i;
				end
			end
		end
		if (best < DAY_MINUTES) begin
			count_left = best * MINUTE_SECONDS - sec;
			queued_run = slot_run[idx];
			next_idx = idx;
			next_known = 1'b1;
		end else begin
			next_known = 1'b0;
			if (!pump_level)
				count_left = 0;
		end
	endfunction

	function automatic result_t schedule_step(item_t w);
		result_t r;
		int unsigned n;
		case (w.kind)
			KIND_TICK: begin
				if (count_left != 0) begin
					count_left--;
					if (count_left == 0) begin
						pump_level = !pump_level;
						if (pump_level)
							count_left = queued_run;
						else
							slot_scan(w.now_hour, w.now_minute, w.now_second);
					end
				end
			end
			KIND_WRITE: begin
				n = w.slot_number;
				if (n >= 1 && n <= NSLOT) begin
					if (w.start_hour > MAX_HOUR || w.start_minute > MAX_MINUTE
							|| w.run_seconds == 0) begin
						slot_hour[n - 1] = '0;
						slot_minute[n - 1] = '0;
						slot_run[n - 1] = '0;
					end else begin
						slot_hour[n - 1] = w.start_hour;
						slot_minute[n - 1] = w.start_minute;
						slot_run[n - 1] = w.run_seconds;
					end
				end
			end
			KIND_MANUAL: begin
				if (w.manual_seconds != 0) begin
					count_left = w.manual_seconds;
					pump_level = 1'b1;
				end
			end
			default: slot_scan(w.now_hour, w.now_minute, w.now_second);
		endcase
		r = '0;
		r.pump_on = pump_level;
		if (pump_level)
			r.remaining_run = (count_left > 16'hFFFF) ? 16'hFFFF : 16'(count_left);
		else
			r.seconds_to_start = 17'(count_left);
		r.next_found = next_known;
		if (next_known) begin
			r.next_slot = 4'(next_idx);
			r.next_hour = slot_hour[next_idx];
			r.next_minute = slot_minute[next_idx];
			r.next_duration = queued_run;
		end
		return r;
	endfunction

	function automatic item_t rand_word();
		item_t w;
		w.kind = kind_t'($urandom_range(0, 3));
		w.now_hour = 5'($urandom);
		w.now_minute = 6'($urandom);
		w.now_second = 6'($urandom);
		w.slot_number = 4'($urandom);
		w.start_hour = 5'($urandom);
		w.start_minute = 6'($urandom);
		w.run_seconds = 16'($urandom);
		w.slot_enabled = 1'($urandom);
		w.manual_seconds = 16'($urandom);
		return w;
	endfunction

	function automatic item_t time_word(kind_t k, int unsigned h, int unsigned m,
			int unsigned s);
		item_t w;
		w = rand_word();
		w.kind = k;
		w.now_hour = 5'(h);
		w.now_minute = 6'(m);
		w.now_second = 6'(s);
		return w;
	endfunction

	function automatic item_t write_word(int unsigned n, int unsigned h, int unsigned m,
			int unsigned d, int unsigned en);
		item_t w;
		w = rand_word();
		w.kind = KIND_WRITE;
		w.slot_number = 4'(n);
		w.start_hour = 5'(h);
		w.start_minute = 6'(m);
		w.run_seconds = 16'(d);
		w.slot_enabled = 1'(en);
		return w;
	endfunction

	function automatic item_t manual_word(int unsigned d);
		item_t w;
		w = rand_word();
		w.kind = KIND_MANUAL;
		w.manual_seconds = 16'(d);
		return w;
	endfunction

	function automatic item_t now_word(kind_t k);
		return time_word(k, day_sec / 3600, (day_sec / 60) % 60, day_sec % 60);
	endfunction

	task automatic queue_ticks(int unsigned n);
		repeat (n) begin
			pending_words.push_back(now_word(KIND_TICK));
			day_sec = (day_sec + 1) % (DAY_MINUTES * MINUTE_SECONDS);
		end
	endtask

	task automatic compare_field(string field, logic [16:0] want, logic [16:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch in %s: expected %0d, got %0d", field, want, got);
		end
	endtask

	initial begin
		int unsigned directed_words, minute_of_day, offset;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		for (int i = 0; i < NSLOT; i++) begin
			slot_hour[i] = '0;
			slot_minute[i] = '0;
			slot_run[i] = '0;
		end
		count_left = 0;
		queued_run = '0;
		pump_level = 1'b0;
		next_idx = 0;
		next_known = 1'b0;

		pending_words.push_back(time_word(KIND_TICK, 31, 63, 63));
		pending_words.push_back(time_word(KIND_RESCHED, 12, 0, 0));
		pending_words.push_back(write_word(0, 1, 1, 5, 1));
		pending_words.push_back(write_word(15, 1, 1, 5, 1));
		pending_words.push_back(write_word(NSLOT + 1, 1, 1, 5, 1));
		pending_words.push_back(write_word(2, 5, 30, 100, 1));
		pending_words.push_back(write_word(2, 24, 30, 100, 1));
		pending_words.push_back(write_word(3, 6, 60, 100, 0));
		pending_words.push_back(write_word(4, 7, 10, 0, 1));
		pending_words.push_back(write_word(1, 0, 0, 65535, 1));
		pending_words.push_back(write_word(5, 0, 0, 7, 0));
		pending_words.push_back(write_word(NSLOT, 23, 59, 1, 0));
		pending_words.push_back(time_word(KIND_RESCHED, 23, 59, 59));
		pending_words.push_back(time_word(KIND_RESCHED, 31, 63, 63));
		pending_words.push_back(time_word(KIND_TICK, 3, 4, 5));
		pending_words.push_back(time_word(KIND_TICK, 3, 4, 6));
		pending_words.push_back(time_word(KIND_RESCHED, 0, 0, 0));
		pending_words.push_back(manual_word(0));
		pending_words.push_back(manual_word(65535));
		pending_words.push_back(manual_word(1));
		pending_words.push_back(time_word(KIND_TICK, 23, 58, 59));
		pending_words.push_back(write_word(NSLOT, 30, 0, 9, 1));
		pending_words.push_back(time_word(KIND_TICK, 31, 63, 63));
		pending_words.push_back(time_word(KIND_TICK, 31, 63, 63));
		directed_words = pending_words.size();

		day_sec = $urandom_range(0, DAY_MINUTES * MINUTE_SECONDS - 1);
		while (pending_words.size() < directed_words + RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					repeat ($urandom_range(1, 3)) begin
						offset = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 1;
						minute_of_day = (day_sec / 60 + offset) % DAY_MINUTES;
						pending_words.push_back(write_word($urandom_range(1, NSLOT),
							minute_of_day / 60, minute_of_day % 60,
							$urandom_range(1, 12), $urandom_range(0, 1)));
					end
					pending_words.push_back(now_word(KIND_RESCHED));
					queue_ticks($urandom_range(20, 100));
				end
				5, 6: begin
					pending_words.push_back(manual_word($urandom_range(1, 8)));
					queue_ticks($urandom_range(1, 12));
				end
				7: begin
					repeat ($urandom_range(1, 3))
						pending_words.push_back(rand_word());
				end
				default: begin
					case ($urandom_range(0, 5))
						0: pending_words.push_back(write_word(
							$urandom_range(0, 1) ? 0 : $urandom_range(NSLOT + 1, 15),
							$urandom_range(0, 23), $urandom_range(0, 59),
							$urandom_range(1, 65535), $urandom_range(0, 1)));
						1: pending_words.push_back(write_word($urandom_range(1, NSLOT),
							$urandom_range(24, 31), $urandom_range(0, 59),
							$urandom_range(1, 65535), $urandom_range(0, 1)));
						2: pending_words.push_back(write_word($urandom_range(1, NSLOT),
							$urandom_range(0, 23), $urandom_range(60, 63),
							$urandom_range(1, 65535), $urandom_range(0, 1)));
						3: pending_words.push_back(write_word($urandom_range(1, NSLOT),
							$urandom_range(0, 23), $urandom_range(0, 59), 0,
							$urandom_range(0, 1)));
						4: pending_words.push_back(manual_word(0));
						default: pending_words.push_back(time_word(KIND_RESCHED,
							$urandom_range(0, 31), $urandom_range(0, 63),
							$urandom_range(0, 63)));
					endcase
				end
			endcase
		end
		total_words = pending_words.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (sent_count == total_words && start == 1'b0);
		wait (expected_status.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	always @(negedge clk) begin : drive_words
		int unsigned idle_pct;
		if (sent_count * 3 < total_words)
			idle_pct = 27;
		else if (sent_count * 3 < total_words * 2)
			idle_pct = 47;
		else
			idle_pct = 0;
		if (arst_n && (!start || word_taken)) begin
			if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				item <= pending_words.pop_front();
				start <= 1'b1;
				sent_count++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		result_t want;
		if (done === 1'b1) begin
			if (expected_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result word with none expected: %h", result);
			end else begin
				want = expected_status.pop_front();
				compare_field("pump_on", want.pump_on, result.pump_on);
				compare_field("remaining_run", want.remaining_run, result.remaining_run);
				compare_field("seconds_to_start", want.seconds_to_start,
					result.seconds_to_start);
				compare_field("next_found", want.next_found, result.next_found);
				compare_field("next_slot", want.next_slot, result.next_slot);
				compare_field("next_hour", want.next_hour, result.next_hour);
				compare_field("next_minute", want.next_minute, result.next_minute);
				compare_field("next_duration", want.next_duration, result.next_duration);
			end
		end
		word_taken = arst_n && start === 1'b1 && busy === 1'b0;
		if (word_taken)
			expected_status.push_back(schedule_step(item));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
design/dsps_pkg.sv
design/dsps_datapath.sv
design/dsps_control.sv
design/daily_slot_pump_scheduler.sv
design/dsps_check.sv
sim/tb_top.sv
